// ===== src/csqm_pkg.sv =====
// ----------------------------------------------------------------------------
// csqm_pkg
// types and constants shared by the signal quality monitor
// ----------------------------------------------------------------------------
package csqm_pkg;

   typedef enum logic [1:0] {
      OP_FRAME  = 2'd0,
      OP_TICK   = 2'd1,
      OP_DEFINE = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   localparam logic [2:0] Q_NEVER = 3'd0;
   localparam logic [2:0] Q_GOOD  = 3'd1;
   localparam logic [2:0] Q_STALE = 3'd2;
   localparam logic [2:0] Q_RANGE = 3'd3;
   localparam logic [2:0] Q_STEP  = 3'd4;

   localparam logic KIND_QUALITY = 1'b0;
   localparam logic KIND_VALUE   = 1'b1;

   localparam int MAX_RESULTS = 16;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [3:0]         slot;
      logic [28:0]        frame_id;
      logic signed [31:0] sample;
      logic [31:0]        time_ms;
      logic signed [31:0] range_low;
      logic signed [31:0] range_high;
      logic [30:0]        step_limit;
      logic               smooth_on;
      logic [7:0]         window_len;
      logic [31:0]        stale_after_ms;
   } req_type;

   typedef struct packed {
      logic               event_kind;
      logic [3:0]         signal_slot;
      logic [2:0]         quality_code;
      logic signed [31:0] smoothed;
      logic               last_event;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_EVAL,
      ST_SUM,
      ST_DIV,
      ST_FINISH,
      ST_TICK,
      ST_EMIT,
      ST_DONE
   } state_type;

   // word travelling along the row of cells
   typedef struct packed {
      logic        hit;
      logic        live;
      logic [28:0] frame_id;
   } probe_type;

endpackage

// ===== src/csqm_cell.sv =====
// ----------------------------------------------------------------------------
// csqm_cell
// one table slot: definition, run-time state and history row; passes the
// lookup word to its neighbor each cycle
// ----------------------------------------------------------------------------
module csqm_cell
   import csqm_pkg::*;
#(
   parameter int HISTORY = 8,
   parameter int HW      = (HISTORY > 1) ? $clog2(HISTORY) : 1,
   parameter int WW      = $clog2(HISTORY + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               def_we,
   input  req_type            def_req,
   input  probe_type          probe_in,
   output probe_type          probe_out,
   output logic               match,
   output logic               valid,
   output logic               seen,
   output logic signed [31:0] low,
   output logic signed [31:0] high,
   output logic [30:0]        step,
   output logic [WW-1:0]      window,
   output logic [31:0]        timeout,
   output logic [2:0]         quality,
   output logic signed [31:0] last_value,
   output logic [31:0]        last_time,
   output logic [HW-1:0]      hist_pos,
   input  logic [HW-1:0]      hist_rd,
   output logic signed [31:0] hist_data,
   input  logic               upd_we,
   input  logic               upd_hist_we,
   input  logic signed [31:0] upd_value,
   input  logic [31:0]        upd_time,
   input  logic [HW-1:0]      upd_pos,
   input  logic [HW-1:0]      upd_next_pos,
   input  logic               q_we,
   input  logic [2:0]         q_value
);

   logic               valid_ff, seen_ff;
   logic [28:0]        id_ff;
   logic signed [31:0] low_ff, high_ff;
   logic [30:0]        step_ff;
   logic [WW-1:0]      window_ff;
   logic [31:0]        timeout_ff;
   logic [2:0]         quality_ff;
   logic signed [31:0] last_value_ff;
   logic [31:0]        last_time_ff;
   logic [HW-1:0]      pos_ff;
   logic signed [31:0] hist_ff [HISTORY];
   probe_type          probe_ff;
   logic               match_in;
   logic [WW-1:0]      window_in;

   assign match_in = valid_ff && (id_ff == probe_in.frame_id) && probe_in.live;

   always_comb begin
      window_in = '0;
      if (def_req.smooth_on && def_req.window_len >= 8'd1 &&
          def_req.window_len <= 8'(HISTORY))
         window_in = WW'(def_req.window_len);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         seen_ff       <= 1'b0;
         quality_ff    <= Q_NEVER;
         last_value_ff <= '0;
         last_time_ff  <= '0;
         pos_ff        <= '0;
         probe_ff      <= '0;
         for (int i = 0; i < HISTORY; i++) hist_ff[i] <= '0;
      end else begin
         probe_ff.frame_id <= probe_in.frame_id;
         probe_ff.live     <= probe_in.live;
         probe_ff.hit      <= probe_in.hit | match_in;
         if (def_we) begin
            valid_ff      <= 1'b1;
            seen_ff       <= 1'b0;
            quality_ff    <= Q_NEVER;
            last_value_ff <= '0;
            last_time_ff  <= '0;
            pos_ff        <= '0;
            for (int i = 0; i < HISTORY; i++) hist_ff[i] <= '0;
         end else begin
            if (upd_we) begin
               seen_ff       <= 1'b1;
               last_value_ff <= upd_value;
               last_time_ff  <= upd_time;
            end
            if (upd_hist_we) begin
               hist_ff[upd_pos] <= upd_value;
               pos_ff           <= upd_next_pos;
            end
            if (q_we) quality_ff <= q_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (def_we) begin
         id_ff      <= def_req.frame_id;
         low_ff     <= def_req.range_low;
         high_ff    <= def_req.range_high;
         step_ff    <= def_req.step_limit;
         window_ff  <= window_in;
         timeout_ff <= def_req.stale_after_ms;
      end
   end

   assign probe_out  = probe_ff;
   // first match only: no earlier cell has claimed the word
   assign match      = match_in && !probe_in.hit;
   assign valid      = valid_ff;
   assign seen       = seen_ff;
   assign low        = low_ff;
   assign high       = high_ff;
   assign step       = step_ff;
   assign window     = window_ff;
   assign timeout    = timeout_ff;
   assign quality    = quality_ff;
   assign last_value = last_value_ff;
   assign last_time  = last_time_ff;
   assign hist_pos   = pos_ff;
   assign hist_data  = hist_ff[hist_rd];

endmodule

// ===== src/csqm_divider.sv =====
// ----------------------------------------------------------------------------
// csqm_divider
// restoring divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module csqm_divider
   import csqm_pkg::*;
#(
   parameter int WW = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [39:0] dividend,
   input  logic [WW-1:0]      divisor,
   output logic               done,
   output logic signed [31:0] quotient
);

   logic [39:0] rem_ff, quo_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff, neg_ff, done_ff;
   logic [39:0] trial;
   logic [39:0] shifted;
   logic [39:0] mag;
   logic [39:0] signed_q;

   assign mag     = dividend[39] ? 40'(-dividend) : 40'(dividend);
   assign shifted = {rem_ff[38:0], quo_ff[39]};
   assign trial   = shifted - 40'(divisor);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd40;
            rem_ff  <= '0;
            quo_ff  <= mag;
            neg_ff  <= dividend[39];
         end else if (busy_ff) begin
            if (!trial[39]) begin
               rem_ff <= trial;
               quo_ff <= {quo_ff[38:0], 1'b1};
            end else begin
               rem_ff <= shifted;
               quo_ff <= {quo_ff[38:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign signed_q = neg_ff ? 40'(-quo_ff) : quo_ff;
   assign done     = done_ff;
   assign quotient = signed_q[31:0];

endmodule

// ===== src/can_signal_quality_monitor.sv =====
// ----------------------------------------------------------------------------
// can_signal_quality_monitor
// signal plausibility and timeout monitor over a row of slot cells
// ----------------------------------------------------------------------------
// order: frame SEARCH, EVAL, then SUM, DIV, FINISH with an averaging window,
// EMIT, DONE; tick TICK, EMIT, DONE, then one word a cycle while rsp_ready holds
// throughput: one word in flight; req_ready returns once DONE has issued the
// last result word, stays high through a define; the divider runs 40 steps
// reset: synchronous, clears all slots, histories and quality; no sweep
module can_signal_quality_monitor
   import csqm_pkg::*;
#(
   parameter int SIGNALS = 16,
   parameter int HISTORY = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int SW = (SIGNALS > 1) ? $clog2(SIGNALS) : 1;
   localparam int HW = (HISTORY > 1) ? $clog2(HISTORY) : 1;
   localparam int WW = $clog2(HISTORY + 1);
   localparam int CW = $clog2(SIGNALS + 2);

   state_type state_ff, state_in;
   req_type   req_ff;
   logic [CW-1:0] cnt_ff;
   logic [SW-1:0] sel_ff;
   logic [HW-1:0] hidx_ff;
   logic signed [39:0] sum_ff;
   logic [2:0]    prevq_ff;
   logic          good_chg_ff;
   logic signed [31:0] avg_ff;
   logic [4:0]    nemit_ff;
   rsp_type       out_ff;
   logic          out_valid_ff;
   logic [SIGNALS-1:0] stale_ff;

   probe_type chain [SIGNALS+1];
   logic [SIGNALS-1:0] match_v, valid_v, seen_v, def_we_v, upd_we_v, hist_we_v, q_we_v;
   logic signed [31:0] low_v [SIGNALS];
   logic signed [31:0] high_v [SIGNALS];
   logic [30:0]   step_v [SIGNALS];
   logic [WW-1:0] win_v [SIGNALS];
   logic [31:0]   tmo_v [SIGNALS];
   logic [2:0]    q_v [SIGNALS];
   logic signed [31:0] lv_v [SIGNALS];
   logic [31:0]   lt_v [SIGNALS];
   logic [HW-1:0] pos_v [SIGNALS];
   logic signed [31:0] hd_v [SIGNALS];
   logic [2:0]    qval;
   logic [HW-1:0] upd_pos, upd_next;

   logic          found_ff;
   logic          accept, out_free;
   logic          div_start, div_done;
   logic signed [31:0] div_q;

   // selected slot view
   logic signed [31:0] s_low, s_high, s_last;
   logic [30:0]   s_step;
   logic [WW-1:0] s_win;
   logic [2:0]    s_q;
   logic [HW-1:0] s_pos;
   logic signed [32:0] diff;
   logic [32:0]   adiff;
   logic          out_range, step_bad;
   logic [31:0]   elapsed;
   logic [SW-1:0] tick_idx;
   logic          tick_hit;

   logic          pend_q_ff, pend_v_ff;
   logic [2:0]    pend_code_ff;
   logic [SIGNALS-1:0] low_bit;
   logic          done_more;

   assign accept   = req_valid && req_ready;
   assign out_free = !out_valid_ff || rsp_ready;

   assign chain[0].hit      = 1'b0;
   assign chain[0].live     = (state_ff == ST_SEARCH);
   assign chain[0].frame_id = req_ff.frame_id;

   genvar g;
   generate
      for (g = 0; g < SIGNALS; g++) begin : g_cell
         csqm_cell #(.HISTORY(HISTORY)) u_cell (
            .clock(clock), .reset(reset),
            .def_we(def_we_v[g]), .def_req(req_data),
            .probe_in(chain[g]), .probe_out(chain[g+1]),
            .match(match_v[g]), .valid(valid_v[g]), .seen(seen_v[g]),
            .low(low_v[g]), .high(high_v[g]), .step(step_v[g]), .window(win_v[g]),
            .timeout(tmo_v[g]), .quality(q_v[g]), .last_value(lv_v[g]),
            .last_time(lt_v[g]), .hist_pos(pos_v[g]), .hist_rd(hidx_ff),
            .hist_data(hd_v[g]),
            .upd_we(upd_we_v[g]), .upd_hist_we(hist_we_v[g]),
            .upd_value(req_ff.sample), .upd_time(req_ff.time_ms),
            .upd_pos(upd_pos), .upd_next_pos(upd_next),
            .q_we(q_we_v[g]), .q_value(qval)
         );
         assign def_we_v[g] = accept && req_data.opcode == OP_DEFINE &&
                              req_data.slot == 4'(g);
      end
   endgenerate

   assign s_low  = low_v[sel_ff];
   assign s_high = high_v[sel_ff];
   assign s_last = lv_v[sel_ff];
   assign s_step = step_v[sel_ff];
   assign s_win  = win_v[sel_ff];
   assign s_q    = q_v[sel_ff];
   assign s_pos  = pos_v[sel_ff];

   assign diff      = 33'(req_ff.sample) - 33'(s_last);
   assign adiff     = diff[32] ? 33'(-diff) : 33'(diff);
   assign out_range = (req_ff.sample < s_low) || (req_ff.sample > s_high);
   assign step_bad  = (s_step != '0) && (s_q == Q_GOOD || s_q == Q_STALE) &&
                      (adiff > 33'(s_step));
   assign upd_pos   = (WW'(s_pos) >= s_win) ? '0 : s_pos;
   assign upd_next  = (WW'(upd_pos) + WW'(1) >= s_win) ? '0 : HW'(WW'(upd_pos) + WW'(1));

   assign tick_idx = SW'(cnt_ff);
   assign elapsed  = req_ff.time_ms - lt_v[tick_idx];
   assign tick_hit = valid_v[tick_idx] && seen_v[tick_idx] &&
                     elapsed >= tmo_v[tick_idx] && q_v[tick_idx] != Q_STALE;

   // words still to issue in DONE
   assign done_more = pend_q_ff || pend_v_ff || |stale_ff;
   assign low_bit   = stale_ff & (~stale_ff + SIGNALS'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:
            if (accept && req_data.opcode == OP_FRAME) state_in = ST_SEARCH;
            else if (accept && req_data.opcode == OP_TICK) state_in = ST_TICK;
         ST_SEARCH:
            if (32'(cnt_ff) == SIGNALS) state_in = found_ff ? ST_EVAL : ST_IDLE;
         ST_EVAL:
            if (out_range || step_bad || s_win == '0) state_in = ST_EMIT;
            else state_in = ST_SUM;
         ST_SUM:
            if (32'(hidx_ff) + 1 >= 32'(s_win)) state_in = ST_DIV;
         ST_DIV:
            if (div_done) state_in = ST_FINISH;
         ST_FINISH:
            state_in = ST_EMIT;
         ST_TICK:
            if (32'(cnt_ff) == SIGNALS) state_in = ST_EMIT;
         ST_EMIT:
            state_in = ST_DONE;
         ST_DONE:
            if (!done_more) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // cell write strobes
   always_comb begin
      upd_we_v  = '0;
      hist_we_v = '0;
      q_we_v    = '0;
      qval      = Q_GOOD;
      if (state_ff == ST_EVAL) begin
         upd_we_v[sel_ff] = 1'b1;
         q_we_v[sel_ff]   = 1'b1;
         qval = out_range ? Q_RANGE : (step_bad ? Q_STEP : Q_GOOD);
         if (!out_range && !step_bad && s_win != '0) hist_we_v[sel_ff] = 1'b1;
      end else if (state_ff == ST_TICK && 32'(cnt_ff) < SIGNALS && tick_hit) begin
         q_we_v[tick_idx] = 1'b1;
         qval = Q_STALE;
      end
   end

   assign div_start = (state_ff == ST_SUM) && (32'(hidx_ff) + 1 >= 32'(s_win));

   csqm_divider #(.WW(WW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(sum_ff + 40'(hd_v[sel_ff])), .divisor(s_win),
      .done(div_done), .quotient(div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
         nemit_ff     <= '0;
         stale_ff     <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: begin
               cnt_ff   <= '0;
               found_ff <= 1'b0;
               nemit_ff <= '0;
               stale_ff <= '0;
               hidx_ff  <= '0;
               sum_ff   <= '0;
               if (accept) req_ff <= req_data;
            end
            ST_SEARCH: begin
               cnt_ff <= cnt_ff + CW'(1);
               // cell k sees the fresh lookup word when the search counter equals k
               if (32'(cnt_ff) < SIGNALS && match_v[tick_idx] && !found_ff) begin
                  found_ff <= 1'b1;
                  sel_ff   <= tick_idx;
               end
            end
            ST_EVAL: begin
               prevq_ff    <= s_q;
               avg_ff      <= req_ff.sample;
               good_chg_ff <= (s_q != Q_GOOD);
            end
            ST_SUM: begin
               sum_ff  <= sum_ff + 40'(hd_v[sel_ff]);
               hidx_ff <= hidx_ff + HW'(1);
            end
            ST_FINISH: avg_ff <= div_q;
            ST_TICK: begin
               if (32'(cnt_ff) < SIGNALS && tick_hit) stale_ff[tick_idx] <= 1'b1;
               cnt_ff <= cnt_ff + CW'(1);
            end
            // tick words retire one per emitted word
            ST_DONE: begin
               if (out_free && !pend_q_ff && !pend_v_ff && |stale_ff) begin
                  nemit_ff <= nemit_ff + 5'd1;
                  stale_ff <= (32'(nemit_ff) < MAX_RESULTS - 1) ?
                              (stale_ff & ~low_bit) : '0;
               end
            end
            default: ;
         endcase
         if (state_ff == ST_TICK && 32'(cnt_ff) == SIGNALS) cnt_ff <= '0;
      end
   end

   // output sequencer: emits words from ST_EMIT/ST_DONE handling below
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_q_ff    <= 1'b0;
         pend_v_ff    <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_ready) out_valid_ff <= 1'b0;
         if (state_ff == ST_EMIT) begin
            if (req_ff.opcode == OP_FRAME) begin
               pend_code_ff <= q_v[sel_ff];
               pend_q_ff    <= (q_v[sel_ff] != prevq_ff) &&
                               !(q_v[sel_ff] == Q_GOOD && !good_chg_ff);
               pend_v_ff    <= (q_v[sel_ff] == Q_GOOD);
            end else begin
               pend_q_ff <= 1'b0;
               pend_v_ff <= 1'b0;
            end
         end
         if (state_ff == ST_DONE && out_free) begin
            if (pend_q_ff) begin
               out_valid_ff          <= 1'b1;
               out_ff.event_kind     <= KIND_QUALITY;
               out_ff.signal_slot    <= 4'(sel_ff);
               out_ff.quality_code   <= pend_code_ff;
               out_ff.smoothed       <= '0;
               out_ff.last_event     <= !pend_v_ff;
               pend_q_ff             <= 1'b0;
            end else if (pend_v_ff) begin
               out_valid_ff          <= 1'b1;
               out_ff.event_kind     <= KIND_VALUE;
               out_ff.signal_slot    <= 4'(sel_ff);
               out_ff.quality_code   <= Q_GOOD;
               out_ff.smoothed       <= avg_ff;
               out_ff.last_event     <= 1'b1;
               pend_v_ff             <= 1'b0;
            end else if (|stale_ff && 32'(nemit_ff) < MAX_RESULTS) begin
               out_valid_ff <= 1'b1;
               for (int i = SIGNALS - 1; i >= 0; i--)
                  if (stale_ff[i]) out_ff.signal_slot <= 4'(i);
               out_ff.event_kind   <= KIND_QUALITY;
               out_ff.quality_code <= Q_STALE;
               out_ff.smoothed     <= '0;
               out_ff.last_event   <= ($countones(stale_ff) == 1) ||
                                      (32'(nemit_ff) == MAX_RESULTS - 1);
            end
         end
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== bench/tb_can_signal_quality_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_can_signal_quality_monitor
// drives define, frame and tick words into the quality monitor, predicts the
// quality and smoothed value events from a model of the slot table, and
// compares every result word in order under random sender and receiver stalls
// ----------------------------------------------------------------------------
module tb_can_signal_quality_monitor;
   import csqm_pkg::*;

   localparam int NSIG = 16;
   localparam int NHIST = 8;
   localparam int IDLE_LIMIT = 20000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   can_signal_quality_monitor uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // slot table copy
   logic               tbl_valid [NSIG];
   logic [28:0]        tbl_id [NSIG];
   logic signed [31:0] tbl_low [NSIG];
   logic signed [31:0] tbl_high [NSIG];
   logic [30:0]        tbl_step [NSIG];
   logic [3:0]         tbl_window [NSIG];
   logic [31:0]        tbl_timeout [NSIG];
   logic [2:0]         tbl_quality [NSIG];
   logic               tbl_seen [NSIG];
   logic signed [31:0] tbl_last_value [NSIG];
   logic [31:0]        tbl_last_time [NSIG];
   logic [3:0]         tbl_pos [NSIG];
   logic signed [31:0] tbl_hist [NSIG][NHIST];

   req_type pending_words [$];
   rsp_type expected_events [$];
   int      mismatches = 0;
   int      idle_cycles = 0;
   int      send_idle_pct;
   int      stall_pct;
   bit      hold_send;
   bit      timed_out = 1'b0;
   int      new_events;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void push_event(logic kind, int s, logic [2:0] q,
                                      logic signed [31:0] v);
      rsp_type r;
      if (new_events >= MAX_RESULTS) return;
      r.event_kind = kind;
      r.signal_slot = s[3:0];
      r.quality_code = q;
      r.smoothed = v;
      r.last_event = 1'b0;
      expected_events.push_back(r);
      new_events++;
   endfunction

   function automatic void change_quality(int s, logic [2:0] q);
      if (tbl_quality[s] == q) return;
      tbl_quality[s] = q;
      push_event(KIND_QUALITY, s, q, 32'sd0);
   endfunction

   function automatic void predict_events(req_type w);
      int s;
      logic signed [31:0] prev;
      logic signed [31:0] avg;
      longint d;
      longint sum;
      int pos;
      int wl;
      bit bad;
      new_events = 0;
      case (w.opcode)
         OP_DEFINE: begin
            s = w.slot;
            tbl_valid[s] = 1'b1;
            tbl_id[s] = w.frame_id;
            tbl_low[s] = w.range_low;
            tbl_high[s] = w.range_high;
            tbl_step[s] = w.step_limit;
            tbl_window[s] = (w.smooth_on && w.window_len >= 1 && w.window_len <= NHIST)
                            ? w.window_len[3:0] : 4'd0;
            tbl_timeout[s] = w.stale_after_ms;
            tbl_quality[s] = Q_NEVER;
            tbl_seen[s] = 1'b0;
            tbl_last_value[s] = '0;
            tbl_last_time[s] = '0;
            tbl_pos[s] = '0;
            for (int i = 0; i < NHIST; i++) tbl_hist[s][i] = '0;
         end
         OP_TICK: begin
            for (int i = 0; i < NSIG; i++)
               if (tbl_valid[i] && tbl_seen[i] &&
                   32'(w.time_ms - tbl_last_time[i]) >= tbl_timeout[i])
                  change_quality(i, Q_STALE);
         end
         OP_FRAME: begin
            s = NSIG;
            for (int i = NSIG - 1; i >= 0; i--)
               if (tbl_valid[i] && tbl_id[i] == w.frame_id) s = i;
            if (s < NSIG) begin
               prev = tbl_last_value[s];
               tbl_last_value[s] = w.sample;
               tbl_seen[s] = 1'b1;
               tbl_last_time[s] = w.time_ms;
               if (w.sample < tbl_low[s] || w.sample > tbl_high[s]) begin
                  change_quality(s, Q_RANGE);
               end else begin
                  bad = 1'b0;
                  if (tbl_step[s] != 0 &&
                      (tbl_quality[s] == Q_GOOD || tbl_quality[s] == Q_STALE)) begin
                     d = longint'(w.sample) - longint'(prev);
                     if (d < 0) d = -d;
                     bad = d > longint'(tbl_step[s]);
                  end
                  if (bad) begin
                     change_quality(s, Q_STEP);
                  end else begin
                     wl = tbl_window[s];
                     if (wl >= 1) begin
                        pos = tbl_pos[s];
                        if (pos >= wl) pos = 0;
                        tbl_hist[s][pos] = w.sample;
                        tbl_pos[s] = 4'((pos + 1) % wl);
                        sum = 0;
                        for (int i = 0; i < wl; i++) sum += longint'(tbl_hist[s][i]);
                        avg = 32'(sum / wl);
                     end else begin
                        avg = w.sample;
                     end
                     change_quality(s, Q_GOOD);
                     push_event(KIND_VALUE, s, Q_GOOD, avg);
                  end
               end
            end
         end
         default: ;
      endcase
      if (new_events > 0)
         expected_events[expected_events.size() - 1].last_event = 1'b1;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         for (int i = 0; i < NSIG; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_quality[i] = Q_NEVER;
            tbl_seen[i] = 1'b0;
         end
      end else begin
         if (req_valid && req_ready) predict_events(req_data);
         if (!req_valid || req_ready) begin
            if (pending_words.size() > 0 && !hold_send &&
                $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_words.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected word %p", rsp_data);
            end else if (expected_events[0] !== rsp_data) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", expected_events[0], rsp_data);
               void'(expected_events.pop_front());
            end else begin
               void'(expected_events.pop_front());
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock)
      if (!reset && idle_cycles >= IDLE_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("tb_can_signal_quality_monitor: FAIL");
         $finish;
      end

   function automatic req_type random_fields();
      req_type w;
      w.opcode = OP_FRAME;
      w.slot = 4'($urandom);
      w.frame_id = 29'($urandom_range(7));
      w.sample = $urandom_range(3) == 0 ? $urandom : $signed(32'($urandom_range(4000))) - 2000;
      w.time_ms = $urandom;
      w.range_low = -32'sd1500;
      w.range_high = 32'sd1500;
      w.step_limit = 31'($urandom_range(1500));
      w.smooth_on = 1'($urandom);
      w.window_len = 8'($urandom_range(10));
      w.stale_after_ms = 32'($urandom_range(300));
      return w;
   endfunction

   task automatic add_word(opcode_type op, int s, int id, logic [31:0] t);
      req_type w;
      w = random_fields();
      w.opcode = op;
      w.slot = s[3:0];
      w.frame_id = id[28:0];
      w.time_ms = t;
      pending_words.push_back(w);
   endtask

   task automatic wait_drained();
      while (pending_words.size() > 0 || req_valid || expected_events.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   initial begin
      req_type w;
      logic [31:0] now;
      hold_send = 1'b0;
      send_idle_pct = 0;
      stall_pct = 0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part
      add_word(OP_FRAME, 0, 5, 0);
      add_word(OP_TICK, 0, 0, 32'hffff_ffff);
      w = random_fields();
      w.opcode = OP_DEFINE; w.slot = 4'd0; w.frame_id = 29'h1fff_ffff;
      w.range_low = 32'sh8000_0000; w.range_high = 32'sh7fff_ffff;
      w.step_limit = 31'h7fff_ffff; w.smooth_on = 1'b1; w.window_len = 8'd8;
      w.stale_after_ms = 32'hffff_ffff;
      pending_words.push_back(w);
      w.opcode = OP_DEFINE; w.slot = 4'd15; w.frame_id = 29'd1;
      w.range_low = 32'sd100; w.range_high = -32'sd100; w.step_limit = '0;
      w.smooth_on = 1'b0; w.window_len = 8'd255; w.stale_after_ms = '0;
      pending_words.push_back(w);
      w.opcode = OP_NONE; pending_words.push_back(w);
      w = random_fields(); w.opcode = OP_FRAME; w.frame_id = 29'h1fff_ffff;
      w.sample = 32'sh7fff_ffff; w.time_ms = '0; pending_words.push_back(w);
      w.sample = 32'sh8000_0000; pending_words.push_back(w);
      w.sample = 32'sh8000_0000; w.time_ms = 32'hffff_ffff; pending_words.push_back(w);
      w.frame_id = 29'd1; w.sample = '0; pending_words.push_back(w);
      add_word(OP_TICK, 0, 0, 32'hffff_fffe);
      add_word(OP_TICK, 0, 0, 0);
      wait_drained();
      // each slot its own id with zero timeout: the tick fills the event limit
      for (int i = 0; i < NSIG; i++) begin
         w = random_fields(); w.opcode = OP_DEFINE; w.slot = 4'(i); w.frame_id = 29'(i);
         w.stale_after_ms = '0; w.range_low = 32'sh8000_0000;
         w.range_high = 32'sh7fff_ffff; w.step_limit = '0;
         pending_words.push_back(w);
      end
      for (int i = 0; i < NSIG; i++) add_word(OP_FRAME, 0, i, 7);
      add_word(OP_TICK, 0, 0, 9);
      wait_drained();
      hold_send = 1'b1;
      repeat (50) @(posedge clock);
      hold_send = 1'b0;

      // random part in idling phases
      now = 0;
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = ph == 1 ? 79 : (ph == 3 ? 15 : 0);
         stall_pct = ph == 2 ? 79 : (ph == 3 ? 15 : 0);
         for (int k = 0; k < 35; k++) begin
            w = random_fields();
            now += $urandom_range(120);
            w.time_ms = now;
            case ($urandom_range(9))
               0, 1: w.opcode = OP_DEFINE;
               2, 3: w.opcode = OP_TICK;
               4: begin
                  w.opcode = opcode_type'($urandom_range(3));
                  w.frame_id = 29'($urandom);
               end
               default: w.opcode = OP_FRAME;
            endcase
            if (w.opcode == OP_DEFINE && $urandom_range(4) == 0) begin
               w.range_low = $urandom; w.range_high = $urandom;
               w.step_limit = 31'($urandom);
               w.stale_after_ms = $urandom;
            end
            pending_words.push_back(w);
         end
         wait_drained();
      end

      if (mismatches == 0 && expected_events.size() == 0) begin
         $display("tb_can_signal_quality_monitor: PASS");
      end else begin
         $display("tb_can_signal_quality_monitor: FAIL");
      end
      $finish;
   end

endmodule
